>>> hw/rtl/mwcs_pkg.sv
//------------------------------------------------------------------------------
// mwcs_pkg
// Shared types and constants of the mecanum wheel command shaper.
//------------------------------------------------------------------------------
`default_nettype none

package mwcs_pkg;

    localparam int CMD_W   = 16;   // input reference and wheel command width
    localparam int LIM_W   = 16;   // acc_limit, vel_limit, wheel_separation width
    localparam int GAIN_W  = 20;   // ik_gain width
    localparam int QUOT_W  = 16;   // scaled magnitude never exceeds a 16 bit limit
    localparam int IK_FRAC = 8;    // fraction bits of ik_gain
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_ACC_LIMIT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VEL_LIMIT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WHEEL_SEP = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_IK_GAIN   = 2'd3;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_YAW_MUL,
        ST_YAW,
        ST_NORM_ACC,
        ST_SCL_MUL,
        ST_SCL_START,
        ST_SCL_WAIT,
        ST_ADD,
        ST_NORM_VEL,
        ST_SAT,
        ST_WHL_MUL,
        ST_WHL_WB,
        ST_OUT
    } state_t;

endpackage

`default_nettype wire

>>> hw/rtl/mwcs_div.sv
//------------------------------------------------------------------------------
// mwcs_div
// Iterative restoring divider, one quotient bit per cycle. The caller
// guarantees that the quotient fits in QUOT_W bits.
//------------------------------------------------------------------------------
`default_nettype none

module mwcs_div #(
    parameter int DVD_W = 36,
    parameter int DVS_W = 22
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       start,
    input  wire logic [DVD_W-1:0]           dividend,
    input  wire logic [DVS_W-1:0]           divisor,
    output logic                            busy,
    output logic                            done,
    output logic [mwcs_pkg::QUOT_W-1:0]     quotient
);
    import mwcs_pkg::*;

    localparam int CNT_W = $clog2(QUOT_W + 1);

    logic [DVS_W-1:0]  rem_reg, rem_next;
    logic [DVS_W-1:0]  dvs_reg;
    logic [QUOT_W-1:0] q_reg, q_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              done_reg, done_next;
    logic [DVS_W:0]    trial;

    assign trial = {rem_reg, q_reg[QUOT_W-1]} - {1'b0, dvs_reg};

    always_comb begin
        rem_next  = rem_reg;
        q_next    = q_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next = DVS_W'(dividend[DVD_W-1:QUOT_W]);
            q_next   = dividend[QUOT_W-1:0];
            cnt_next = CNT_W'(QUOT_W);
        end else if (cnt_reg != '0) begin
            if (!trial[DVS_W]) begin
                rem_next = trial[DVS_W-1:0];
            end else begin
                rem_next = {rem_reg[DVS_W-2:0], q_reg[QUOT_W-1]};
            end
            q_next    = {q_reg[QUOT_W-2:0], ~trial[DVS_W]};
            cnt_next  = cnt_reg - 1'b1;
            done_next = (cnt_reg == CNT_W'(1));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
        rem_reg <= rem_next;
        q_reg   <= q_next;
        if (start) begin
            dvs_reg <= divisor;
        end
    end

    assign busy     = (cnt_reg != '0);
    assign done     = done_reg;
    assign quotient = q_reg;

    a_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        start |-> !busy) else $error("divider started while busy");
    a_rem_below: assert property (@(posedge aclk) disable iff (!aresetn)
        busy && !$past(start) |-> rem_reg < dvs_reg) else $error("remainder overflow");
    a_done_once: assert property (@(posedge aclk) disable iff (!aresetn)
        done |=> !done) else $error("done held for two cycles");

endmodule

`default_nettype wire

>>> hw/rtl/mecanum_wheel_command_shaper_top.sv
//------------------------------------------------------------------------------
// mecanum_wheel_command_shaper_top
// Slew and speed limited mecanum inverse kinematics on one shared multiplier
// and one iterative divider.
//------------------------------------------------------------------------------
//  channel  dir  payload                                        handshake
//  s_       in   tdata: ref_x, ref_y, ref_yaw; tuser: ref_stale tvalid/tready
//  m_       out  tdata: front_left, front_right, rear_right,    tvalid/tready
//                rear_left commands
//  cfg_     in   cfg_index, cfg_wdata                           cfg_wen
//
// Each applied limit adds, per component, a multiply, a divider start and an
// iterative divide before the result is offered. A zero command skips the wheel
// pass. Reset is synchronous and restores the register defaults and a zero
// previous command. The result waits in an output register; no request is taken
// meanwhile.
//------------------------------------------------------------------------------
`default_nettype none

module mecanum_wheel_command_shaper_top #(
    parameter int FRAC_BITS = 12
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    input  wire logic [47:0]                        s_tdata,   // ref_x, ref_y, ref_yaw
    input  wire logic [0:0]                         s_tuser,   // ref_stale
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    output logic [63:0]                             m_tdata,   // fl, fr, rr, rl
    input  wire logic                               cfg_wen,
    input  wire logic [mwcs_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [mwcs_pkg::GAIN_W-1:0]        cfg_wdata
);
    import mwcs_pkg::*;

    localparam int MAG_W = (32 - FRAC_BITS > 18) ? 32 - FRAC_BITS : 18;
    localparam int VW    = MAG_W + 1;
    localparam int NRM_W = MAG_W + 2;
    localparam int PW    = MAG_W + GAIN_W;
    localparam int DVD_W = MAG_W + LIM_W;
    localparam int WSH   = IK_FRAC + FRAC_BITS;

    localparam logic signed [VW-1:0] SAT_HI = VW'(32767);
    localparam logic signed [VW-1:0] SAT_LO = VW'(-32768);
    localparam logic [PW-1:0]        POS_MAX = PW'(32767);
    localparam logic [PW-1:0]        NEG_MAX = PW'(32768);

    state_t state_reg, state_next;

    logic [LIM_W-1:0]  acc_reg, vel_reg, ws_reg, lim_reg;
    logic [GAIN_W-1:0] gain_reg;

    logic signed [CMD_W-1:0] last_reg [3];
    logic signed [VW-1:0]    v_reg [3];
    logic signed [CMD_W-1:0] ryaw_reg;
    logic [NRM_W-1:0]        norm_reg;
    logic [1:0]              idx_reg;
    logic                    pass_reg;
    logic                    wneg_reg;
    logic [CMD_W-1:0]        out_reg [4];
    logic [PW-1:0]           prod_reg;

    logic [MAG_W-1:0]  mul_a;
    logic [GAIN_W-1:0] mul_b;
    logic              div_start, div_busy, div_done;
    logic [QUOT_W-1:0] div_q;

    logic [MAG_W-1:0]     vmag [3];
    logic [NRM_W-1:0]     norm_c;
    logic signed [VW-1:0] wsum;
    logic                 wflip;
    logic [MAG_W-1:0]     wsum_mag;
    logic [MAG_W-1:0]     yaw_mag;
    logic signed [VW-1:0] yaw_val;
    logic [PW-1:0]        wmag;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            vmag[i] = v_reg[i][VW-1] ? MAG_W'(-v_reg[i]) : MAG_W'(v_reg[i]);
        end
        norm_c = NRM_W'(vmag[0]) + NRM_W'(vmag[1]) + NRM_W'(vmag[2]);
    end

    // Wheel mixing: sum and final sign per wheel.
    always_comb begin
        case (idx_reg)
            2'd0: begin wsum = v_reg[0] - v_reg[1] - v_reg[2]; wflip = 1'b0; end
            2'd1: begin wsum = v_reg[0] + v_reg[1] + v_reg[2]; wflip = 1'b1; end
            2'd2: begin wsum = v_reg[0] - v_reg[1] + v_reg[2]; wflip = 1'b1; end
            default: begin wsum = v_reg[0] + v_reg[1] - v_reg[2]; wflip = 1'b0; end
        endcase
        wsum_mag = wsum[VW-1] ? MAG_W'(-wsum) : MAG_W'(wsum);
    end

    assign yaw_mag = MAG_W'(prod_reg >> FRAC_BITS);
    assign yaw_val = ryaw_reg[CMD_W-1] ? -VW'(yaw_mag) : VW'(yaw_mag);
    assign wmag    = prod_reg >> WSH;

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:      if (s_tvalid) state_next = ST_YAW_MUL;
            ST_YAW_MUL:   state_next = ST_YAW;
            ST_YAW:       state_next = ST_NORM_ACC;
            ST_NORM_ACC:  state_next = (norm_c > NRM_W'(acc_reg)) ? ST_SCL_MUL : ST_ADD;
            ST_SCL_MUL:   state_next = ST_SCL_START;
            ST_SCL_START: state_next = ST_SCL_WAIT;
            ST_SCL_WAIT: begin
                if (div_done) begin
                    if (idx_reg != 2'd2) begin
                        state_next = ST_SCL_MUL;
                    end else begin
                        state_next = pass_reg ? ST_SAT : ST_ADD;
                    end
                end
            end
            ST_ADD:       state_next = ST_NORM_VEL;
            ST_NORM_VEL: begin
                if (norm_c == '0) begin
                    state_next = ST_OUT;
                end else if (norm_c > NRM_W'(vel_reg)) begin
                    state_next = ST_SCL_MUL;
                end else begin
                    state_next = ST_SAT;
                end
            end
            ST_SAT:       state_next = ST_WHL_MUL;
            ST_WHL_MUL:   state_next = ST_WHL_WB;
            ST_WHL_WB:    state_next = (idx_reg == 2'd3) ? ST_OUT : ST_WHL_MUL;
            ST_OUT:       if (m_tready) state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    // Control outputs and shared multiplier operands
    always_comb begin
        s_tready  = 1'b0;
        m_tvalid  = 1'b0;
        div_start = 1'b0;
        mul_a     = vmag[idx_reg];
        mul_b     = GAIN_W'(lim_reg);
        case (state_reg)
            ST_IDLE:      s_tready = 1'b1;
            ST_YAW_MUL: begin
                mul_a = ryaw_reg[CMD_W-1] ? MAG_W'(-ryaw_reg) : MAG_W'(ryaw_reg);
                mul_b = GAIN_W'(ws_reg);
            end
            ST_SCL_START: div_start = 1'b1;
            ST_WHL_MUL: begin
                mul_a = wsum_mag;
                mul_b = gain_reg;
            end
            ST_OUT:       m_tvalid = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        prod_reg <= PW'(mul_a) * PW'(mul_b);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            acc_reg   <= LIM_W'(410);
            vel_reg   <= LIM_W'(4096);
            ws_reg    <= LIM_W'(2048);
            gain_reg  <= GAIN_W'(256);
            for (int i = 0; i < 3; i++) begin
                last_reg[i] <= '0;
            end
        end else begin
            state_reg <= state_next;
            if (cfg_wen) begin
                case (cfg_index)
                    CFG_ACC_LIMIT: acc_reg  <= cfg_wdata[LIM_W-1:0];
                    CFG_VEL_LIMIT: vel_reg  <= cfg_wdata[LIM_W-1:0];
                    CFG_WHEEL_SEP: ws_reg   <= cfg_wdata[LIM_W-1:0];
                    CFG_IK_GAIN:   gain_reg <= cfg_wdata;
                    default: ;
                endcase
            end
            // The command is saturated by the time the wheel pass runs.
            if (state_reg == ST_WHL_MUL) begin
                for (int i = 0; i < 3; i++) begin
                    last_reg[i] <= CMD_W'(v_reg[i]);
                end
            end else if (state_reg == ST_NORM_VEL && norm_c == '0) begin
                for (int i = 0; i < 3; i++) begin
                    last_reg[i] <= '0;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                if (s_tuser[0]) begin
                    v_reg[0] <= -VW'(last_reg[0]);
                    v_reg[1] <= -VW'(last_reg[1]);
                    ryaw_reg <= '0;
                end else begin
                    v_reg[0] <= VW'($signed(s_tdata[15:0])) - VW'(last_reg[0]);
                    v_reg[1] <= VW'($signed(s_tdata[31:16])) - VW'(last_reg[1]);
                    ryaw_reg <= $signed(s_tdata[47:32]);
                end
            end
            ST_YAW: v_reg[2] <= yaw_val - VW'(last_reg[2]);
            ST_NORM_ACC: begin
                norm_reg <= norm_c;
                lim_reg  <= acc_reg;
                pass_reg <= 1'b0;
                idx_reg  <= 2'd0;
            end
            ST_SCL_WAIT: begin
                if (div_done) begin
                    v_reg[idx_reg] <= v_reg[idx_reg][VW-1] ? -VW'(div_q) : VW'(div_q);
                    idx_reg <= (idx_reg == 2'd2) ? 2'd0 : idx_reg + 2'd1;
                end
            end
            ST_ADD: begin
                for (int i = 0; i < 3; i++) begin
                    v_reg[i] <= v_reg[i] + VW'(last_reg[i]);
                end
            end
            ST_NORM_VEL: begin
                norm_reg <= norm_c;
                lim_reg  <= vel_reg;
                pass_reg <= 1'b1;
                idx_reg  <= 2'd0;
                for (int k = 0; k < 4; k++) begin
                    out_reg[k] <= '0;
                end
            end
            ST_SAT: begin
                for (int i = 0; i < 3; i++) begin
                    if (v_reg[i] > SAT_HI) begin
                        v_reg[i] <= SAT_HI;
                    end else if (v_reg[i] < SAT_LO) begin
                        v_reg[i] <= SAT_LO;
                    end
                end
                idx_reg <= 2'd0;
            end
            ST_WHL_MUL: wneg_reg <= wsum[VW-1] ^ wflip;
            ST_WHL_WB: begin
                if (wneg_reg) begin
                    out_reg[idx_reg] <= (wmag >= NEG_MAX) ? CMD_W'(16'h8000)
                                                          : CMD_W'(-wmag);
                end else begin
                    out_reg[idx_reg] <= (wmag >= POS_MAX) ? CMD_W'(16'h7FFF)
                                                          : CMD_W'(wmag);
                end
                idx_reg <= idx_reg + 2'd1;
            end
            default: ;
        endcase
    end

    mwcs_div #(
        .DVD_W (DVD_W),
        .DVS_W (NRM_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (prod_reg[DVD_W-1:0]),
        .divisor  (norm_reg),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_q)
    );

    assign m_tdata = {out_reg[3], out_reg[2], out_reg[1], out_reg[0]};

    a_one_side: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid)) else $error("input and output open together");
    a_accept_start: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> state_reg == ST_YAW_MUL) else $error("request not started");
    a_quot_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> div_q <= lim_reg) else $error("scaled value above limit");
    a_div_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_SCL_WAIT && !div_done |-> div_busy) else $error("divider lost");

endmodule

`default_nettype wire
